// File: sv/rme_pkg.sv
`default_nettype none
package rme_pkg;
	localparam int CordicSteps = 16;
	localparam int InW = 16;
	localparam int CW = 36;
	localparam int ZW = 34;
	localparam logic signed [ZW-1:0] HalfPi = 34'sd1686629713;
	localparam logic [29:0] InvGain = 30'd652032874;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic ang_t atan_of(input int i);
		case (i)
			0: atan_of = 34'sh3243F6A8;
			1: atan_of = 34'sh1DAC6705;
			2: atan_of = 34'sh0FADBAFC;
			3: atan_of = 34'sh07F56EA6;
			4: atan_of = 34'sh03FEAB76;
			5: atan_of = 34'sh01FFD55B;
			6: atan_of = 34'sh00FFFAAA;
			7: atan_of = 34'sh007FFF55;
			8: atan_of = 34'sh003FFFEA;
			9: atan_of = 34'sh001FFFFD;
			10: atan_of = 34'sh000FFFFF;
			11: atan_of = 34'sh0007FFFF;
			12: atan_of = 34'sh0003FFFF;
			13: atan_of = 34'sh0001FFFF;
			14: atan_of = 34'sh0000FFFF;
			15: atan_of = 34'sh00007FFF;
			16: atan_of = 34'sh00003FFF;
			17: atan_of = 34'sh00001FFF;
			18: atan_of = 34'sh00000FFF;
			19: atan_of = 34'sh000007FF;
			20: atan_of = 34'sh000003FF;
			21: atan_of = 34'sh000001FF;
			22: atan_of = 34'sh000000FF;
			23: atan_of = 34'sh0000007F;
			default: atan_of = '0;
		endcase
	endfunction

	function automatic logic [15:0] to_q13(input ang_t z);
		ang_t r;
		r = (z + ang_t'(65536)) >>> 17;
		if (r > ang_t'(32767)) to_q13 = 16'h7FFF;
		else if (r < -ang_t'(32768)) to_q13 = 16'h8000;
		else to_q13 = r[15:0];
	endfunction
endpackage
`default_nettype wire

// File: sv/rme_cordic.sv
`default_nettype none
// vectoring cordic, one register stage for the pre-rotation and one per iteration
module rme_cordic (
	input  wire                  clk,
	input  wire                  en,
	input  wire rme_pkg::comp_t  x_in,
	input  wire rme_pkg::comp_t  y_in,
	output rme_pkg::comp_t       mag,
	output rme_pkg::ang_t        ang
);
	import rme_pkg::*;

	comp_t x_s [CordicSteps+1];
	comp_t y_s [CordicSteps+1];
	ang_t  z_s [CordicSteps+1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in; y_s[0] <= -x_in; z_s[0] <= HalfPi;
				end else begin
					x_s[0] <= -y_in; y_s[0] <= x_in; z_s[0] <= -HalfPi;
				end
			end else begin
				x_s[0] <= x_in; y_s[0] <= y_in; z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_of(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_of(i);
				end
			end
		end
	end

	// zero vector ends with y = 0 through all steps but angle drifts; handled by caller
	assign mag = x_s[CordicSteps];
	assign ang = z_s[CordicSteps];
endmodule
`default_nettype wire

// File: sv/rotation_matrix_to_euler_core.sv
`default_nettype none
// throughput: one transaction per cycle while m_axis is not stalled, set by the fully unrolled cordic stages
// stalls freeze the whole pipeline; output tvalid goes low when s_axis is idle
// arst_n clears valid bits and sets the threshold to 1; data registers are not reset
module rotation_matrix_to_euler_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [14:0]  cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [111:0] s_axis_tdata,  // r00, r10, r11, r12, r20, r21, r22
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata   // angle_x, angle_y, angle_z
);
	import rme_pkg::*;

	localparam int C = CordicSteps + 1;
	localparam int Lat = 2 * C + 4;

	logic [14:0] thr_q;
	logic [Lat-1:0] vld_q;
	logic en;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
			vld_q <= '0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
		end
	end

	function automatic comp_t ext(input logic [15:0] v);
		ext = comp_t'($signed(v)) <<< 14;
	endfunction

	// stage 1: unpack into q28 components
	comp_t a00_s1, a10_s1, a11_s1, a12_s1, a20_s1, a21_s1, a22_s1;
	logic zero_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a00_s1 <= ext(s_axis_tdata[15:0]);
			a10_s1 <= ext(s_axis_tdata[31:16]);
			a11_s1 <= ext(s_axis_tdata[47:32]);
			a12_s1 <= ext(s_axis_tdata[63:48]);
			a20_s1 <= ext(s_axis_tdata[79:64]);
			a21_s1 <= ext(s_axis_tdata[95:80]);
			a22_s1 <= ext(s_axis_tdata[111:96]);
			zero_s1 <= s_axis_tdata[31:0] == 32'd0;
		end
	end

	// delay lines beside the first cordic
	comp_t d11 [C], d12 [C], d20 [C], d21 [C], d22 [C];
	logic dz [C];
	always_ff @(posedge clk) begin
		if (en) begin
			d11[0] <= a11_s1; d12[0] <= a12_s1; d20[0] <= a20_s1;
			d21[0] <= a21_s1; d22[0] <= a22_s1; dz[0] <= zero_s1;
			for (int k = 1; k < C; k++) begin
				d11[k] <= d11[k-1]; d12[k] <= d12[k-1]; d20[k] <= d20[k-1];
				d21[k] <= d21[k-1]; d22[k] <= d22[k-1]; dz[k] <= dz[k-1];
			end
		end
	end

	comp_t mag_z;
	ang_t ang_z;
	rme_cordic u_cz (.clk, .en, .x_in(a00_s1), .y_in(a10_s1), .mag(mag_z), .ang(ang_z));

	// stage a: gain product
	logic signed [CW+30:0] prod_s2;
	ang_t az_s2;
	comp_t n11_s2, n12_s2, n20_s2, n21_s2, n22_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= dz[C-1] ? '0 : mag_z * $signed({1'b0, InvGain});
			az_s2 <= dz[C-1] ? '0 : ang_z;
			n11_s2 <= d11[C-1]; n12_s2 <= d12[C-1]; n20_s2 <= d20[C-1];
			n21_s2 <= d21[C-1]; n22_s2 <= d22[C-1];
		end
	end

	// stage b: round, compare, select operands
	logic signed [CW+30:0] rnd;
	comp_t sy;
	logic sing;
	assign rnd = (prod_s2 + (67'sd1 <<< 29)) >>> 30;
	assign sy = rnd[CW-1:0];
	assign sing = sy < comp_t'({thr_q, 14'd0});

	comp_t xa_s3, ya_s3, xb_s3, yb_s3;
	ang_t az_s3;
	logic za_s3, zb_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s3 <= sing ? n11_s2 : n22_s2;
			ya_s3 <= sing ? -n12_s2 : n21_s2;
			za_s3 <= sing ? (n11_s2 == 0 && n12_s2 == 0) : (n22_s2 == 0 && n21_s2 == 0);
			xb_s3 <= sy;
			yb_s3 <= -n20_s2;
			zb_s3 <= sy == 0 && n20_s2 == 0;
			az_s3 <= sing ? '0 : az_s2;
		end
	end

	ang_t azd [C];
	logic zad [C], zbd [C];
	always_ff @(posedge clk) begin
		if (en) begin
			azd[0] <= az_s3; zad[0] <= za_s3; zbd[0] <= zb_s3;
			for (int k = 1; k < C; k++) begin
				azd[k] <= azd[k-1]; zad[k] <= zad[k-1]; zbd[k] <= zbd[k-1];
			end
		end
	end

	comp_t ma, mb;
	ang_t axa, ayb;
	rme_cordic u_cx (.clk, .en, .x_in(xa_s3), .y_in(ya_s3), .mag(ma), .ang(axa));
	rme_cordic u_cy (.clk, .en, .x_in(xb_s3), .y_in(yb_s3), .mag(mb), .ang(ayb));

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {to_q13(azd[C-1]),
				to_q13(zbd[C-1] ? '0 : ayb),
				to_q13(zad[C-1] ? '0 : axa)};
		end
	end

	logic unused_mag;
	assign unused_mag = ^{ma, mb};
endmodule
`default_nettype wire
